// File: sv/spd_pkg.sv
// Shared types and constants of the point distance sorter.
`default_nettype none
package spd_pkg;
	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * COORD_W;
	localparam int KEY_W = 35;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified point request on its way from the front to the sorter
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic last;
		logic drop;
	} spd_entry_t;
endpackage
`default_nettype wire

// File: sv/sort_points_by_distance.sv
// Top level of the point distance sorter.
// Point requests arrive on point_valid/point_ready with point_x/point_y, the
// target on the first point of a set, and set_end on the last point. Results
// leave on sorted_valid/sorted_ready, nearest point first; points at equal
// distance keep arrival order. final_result marks the last result of a set,
// dropped marks every result of a set that held more than MAX_POINTS points.
// Input points are taken one per cycle while point_ready is high. A three-stage
// front end computes the squared distance and feeds a four-entry queue; the
// sorter inserts one point per cycle, while it loads a set, into a chain of
// MAX_POINTS cells. After set_end is taken, that point passes the front stages
// and queue; results then leave one per cycle while the receiver takes them.
// While the sorter drains, the front end keeps taking points of the next set
// until the queue is full. A stalled receiver holds the result register and
// the chain; the queue then fills and point_ready drops.
// Reset empties the queue, the chain and the result register; the first
// point after reset starts a new set.
`default_nettype none
module sort_points_by_distance #(
	parameter int MAX_POINTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic point_valid,
	output logic point_ready,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic signed [15:0] target_x,
	input  wire logic signed [15:0] target_y,
	input  wire logic set_end,
	output logic sorted_valid,
	input  wire logic sorted_ready,
	output logic signed [15:0] sorted_x,
	output logic signed [15:0] sorted_y,
	output logic dropped,
	output logic final_result
);
	logic push_valid, push_ready, pop_valid, pop_ready;
	spd_pkg::spd_entry_t push_entry, pop_entry;

	spd_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(point_valid), .in_ready(point_ready),
		.point_x(point_x), .point_y(point_y),
		.target_x(target_x), .target_y(target_y), .set_end(set_end),
		.push_valid(push_valid), .push_ready(push_ready), .push_entry(push_entry)
	);

	spd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_entry(push_entry),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_entry(pop_entry)
	);

	spd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_entry(pop_entry),
		.out_valid(sorted_valid), .out_ready(sorted_ready),
		.sorted_x(sorted_x), .sorted_y(sorted_y),
		.dropped(dropped), .final_result(final_result)
	);
endmodule
`default_nettype wire

// File: sv/spd_front.sv
// Front end: accepts point requests, samples the target, computes the squared distance.
`default_nettype none
module spd_front #(
	parameter int MAX_POINTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [spd_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [spd_pkg::COORD_W-1:0] point_y,
	input  wire logic signed [spd_pkg::COORD_W-1:0] target_x,
	input  wire logic signed [spd_pkg::COORD_W-1:0] target_y,
	input  wire logic set_end,
	output logic push_valid,
	input  wire logic push_ready,
	output spd_pkg::spd_entry_t push_entry
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic signed [spd_pkg::COORD_W-1:0] tx_q, ty_q;
	logic signed [spd_pkg::COORD_W-1:0] tx, ty;
	logic adv, accept, first;

	logic v_s1, v_s2, v_s3;
	logic signed [spd_pkg::COORD_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic signed [spd_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic last_s1, last_s2, last_s3, drop_s1, drop_s2, drop_s3;
	logic [spd_pkg::SQ_W-1:0] sqx_s2, sqy_s2;
	logic [spd_pkg::KEY_W-1:0] key_s3;
	logic [spd_pkg::DIFF_W-1:0] ax, ay;

	// whole pipe holds while its last stage cannot push
	assign adv = !(v_s3 && !push_ready);
	assign in_ready = adv;
	assign accept = in_valid && in_ready;
	assign first = (cnt_q == '0);
	assign tx = first ? target_x : tx_q;
	assign ty = first ? target_y : ty_q;

	assign ax = dx_s1[spd_pkg::DIFF_W-1] ? -dx_s1 : dx_s1;
	assign ay = dy_s1[spd_pkg::DIFF_W-1] ? -dy_s1 : dy_s1;

	// set bookkeeping: point count and target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
		end else if (accept) begin
			if (first) begin
				tx_q <= target_x;
				ty_q <= target_y;
			end
			if (set_end)
				cnt_q <= '0;
			else if (cnt_q != CNT_W'(MAX_POINTS))
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// datapath: difference, square, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
			dx_s1 <= spd_pkg::DIFF_W'(point_x) - spd_pkg::DIFF_W'(tx);
			dy_s1 <= spd_pkg::DIFF_W'(point_y) - spd_pkg::DIFF_W'(ty);
			last_s1 <= set_end;
			drop_s1 <= (cnt_q == CNT_W'(MAX_POINTS));

			x_s2 <= x_s1;
			y_s2 <= y_s1;
			sqx_s2 <= ax[spd_pkg::COORD_W-1:0] * ax[spd_pkg::COORD_W-1:0];
			sqy_s2 <= ay[spd_pkg::COORD_W-1:0] * ay[spd_pkg::COORD_W-1:0];
			last_s2 <= last_s1;
			drop_s2 <= drop_s1;

			x_s3 <= x_s2;
			y_s3 <= y_s2;
			key_s3 <= spd_pkg::KEY_W'(sqx_s2) + spd_pkg::KEY_W'(sqy_s2);
			last_s3 <= last_s2;
			drop_s3 <= drop_s2;
		end
	end

	assign push_valid = v_s3;
	assign push_entry.key = key_s3;
	assign push_entry.x = x_s3;
	assign push_entry.y = y_s3;
	assign push_entry.last = last_s3;
	assign push_entry.drop = drop_s3;
endmodule
`default_nettype wire

// File: sv/spd_queue.sv
// Short queue between the front end and the sorter.
`default_nettype none
module spd_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic push_ready,
	input  wire spd_pkg::spd_entry_t push_entry,
	output logic pop_valid,
	input  wire logic pop_ready,
	output spd_pkg::spd_entry_t pop_entry
);
	spd_pkg::spd_entry_t entry_q [spd_pkg::QUEUE_DEPTH];
	logic [spd_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [spd_pkg::QCNT_W-1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != spd_pkg::QCNT_W'(spd_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_entry = entry_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_entry;
	end
endmodule
`default_nettype wire

// File: sv/spd_back.sv
// Back end: insertion chain of sorted cells and the result output register.
`default_nettype none
module spd_back #(
	parameter int MAX_POINTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic pop_ready,
	input  wire spd_pkg::spd_entry_t pop_entry,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [spd_pkg::COORD_W-1:0] sorted_x,
	output logic signed [spd_pkg::COORD_W-1:0] sorted_y,
	output logic dropped,
	output logic final_result
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic {LOAD, EMIT} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic [spd_pkg::KEY_W-1:0] key_q [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] x_q [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] y_q [MAX_POINTS];
	logic [MAX_POINTS-1:0] gt, gt_prev, ins_here, take_prev;
	logic [spd_pkg::KEY_W-1:0] key_prev [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] x_prev [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] y_prev [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] x_next [MAX_POINTS];
	logic signed [spd_pkg::COORD_W-1:0] y_next [MAX_POINTS];
	logic [spd_pkg::KEY_W-1:0] key_next [MAX_POINTS];
	logic pop, insert, emit;

	assign pop_ready = (state_q == LOAD);
	assign pop = pop_valid && pop_ready;
	assign insert = pop && !pop_entry.drop;
	assign emit = (state_q == EMIT) && (!out_valid || out_ready);

	// per cell: larger keys move up one place, the new point lands below them
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		assign gt[i] = (CNT_W'(i) < cnt_q) && (key_q[i] > pop_entry.key);
		if (i == 0) begin : g_first
			assign gt_prev[i] = 1'b0;
			assign key_prev[i] = key_q[i];
			assign x_prev[i] = x_q[i];
			assign y_prev[i] = y_q[i];
		end else begin : g_rest
			assign gt_prev[i] = gt[i-1];
			assign key_prev[i] = key_q[i-1];
			assign x_prev[i] = x_q[i-1];
			assign y_prev[i] = y_q[i-1];
		end
		if (i == MAX_POINTS - 1) begin : g_top
			assign key_next[i] = key_q[i];
			assign x_next[i] = x_q[i];
			assign y_next[i] = y_q[i];
		end else begin : g_below
			assign key_next[i] = key_q[i+1];
			assign x_next[i] = x_q[i+1];
			assign y_next[i] = y_q[i+1];
		end
		assign take_prev[i] = gt_prev[i] && (CNT_W'(i) <= cnt_q);
		assign ins_here[i] = (gt[i] || (CNT_W'(i) == cnt_q)) && !gt_prev[i];
	end

	// cell contents
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (insert) begin
				if (take_prev[i]) begin
					key_q[i] <= key_prev[i];
					x_q[i] <= x_prev[i];
					y_q[i] <= y_prev[i];
				end else if (ins_here[i]) begin
					key_q[i] <= pop_entry.key;
					x_q[i] <= pop_entry.x;
					y_q[i] <= pop_entry.y;
				end
			end else if (emit) begin
				key_q[i] <= key_next[i];
				x_q[i] <= x_next[i];
				y_q[i] <= y_next[i];
			end
		end
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			sorted_x <= '0;
			sorted_y <= '0;
			dropped <= 1'b0;
			final_result <= 1'b0;
		end else begin
			// a taken result clears valid unless the next one replaces it
			if (out_valid && out_ready && !emit)
				out_valid <= 1'b0;
			case (state_q)
				LOAD: begin
					if (pop) begin
						if (!pop_entry.drop)
							cnt_q <= cnt_q + 1'b1;
						if (pop_entry.drop)
							ovf_q <= 1'b1;
						if (pop_entry.last)
							state_q <= EMIT;
					end
				end
				EMIT: begin
					if (emit) begin
						out_valid <= 1'b1;
						sorted_x <= x_q[0];
						sorted_y <= y_q[0];
						dropped <= ovf_q;
						final_result <= (cnt_q == CNT_W'(1));
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= LOAD;
							ovf_q <= 1'b0;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/spd_checker.sv
// Port-level checks of the point distance sorter and their bind.
`default_nettype none
module spd_checker #(
	parameter int MAX_POINTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic point_valid,
	input wire logic point_ready,
	input wire logic set_end,
	input wire logic sorted_valid,
	input wire logic sorted_ready,
	input wire logic signed [15:0] sorted_x,
	input wire logic signed [15:0] sorted_y,
	input wire logic dropped,
	input wire logic final_result
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [7:0] open_sets_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic mid_set_q, drop_seen_q;
	logic set_in, set_out, res_out;

	assign set_in = point_valid && point_ready && set_end;
	assign res_out = sorted_valid && sorted_ready;
	assign set_out = res_out && final_result;

	// sets taken but not yet fully delivered, results delivered in this set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_sets_q <= '0;
			res_cnt_q <= '0;
			mid_set_q <= 1'b0;
			drop_seen_q <= 1'b0;
		end else begin
			if (set_in && !set_out)
				open_sets_q <= open_sets_q + 1'b1;
			else if (set_out && !set_in)
				open_sets_q <= open_sets_q - 1'b1;
			if (res_out) begin
				res_cnt_q <= final_result ? '0 : res_cnt_q + 1'b1;
				mid_set_q <= !final_result;
				drop_seen_q <= dropped;
			end
		end
	end

	a_no_result_without_set: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid |-> (open_sets_q != '0))
		else $error("result shown with no finished set pending");

	a_set_size_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid |-> (res_cnt_q < CNT_W'(MAX_POINTS)))
		else $error("more results in one set than the sorter holds");

	a_drop_flag_per_set: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted_valid && mid_set_q) |-> (dropped == drop_seen_q))
		else $error("dropped flag changed inside a set");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted_valid && !sorted_ready) |=>
			(sorted_valid && $stable(sorted_x) && $stable(sorted_y) &&
			$stable(dropped) && $stable(final_result)))
		else $error("stalled result changed");
endmodule

bind sort_points_by_distance spd_checker #(.MAX_POINTS(MAX_POINTS)) u_spd_checker (
	.clk(clk), .arst_n(arst_n),
	.point_valid(point_valid), .point_ready(point_ready), .set_end(set_end),
	.sorted_valid(sorted_valid), .sorted_ready(sorted_ready),
	.sorted_x(sorted_x), .sorted_y(sorted_y),
	.dropped(dropped), .final_result(final_result)
);
`default_nettype wire

// File: test/tb_sort_points_by_distance.sv
`timescale 1ns / 100ps
// Testbench for the point distance sorter: directed and random sets checked against a predictor.
module tb_sort_points_by_distance;
	localparam int CAPACITY = 32;
	localparam int HALF_PERIOD = 4;
	localparam int MAX_REPORTS = 10;

	typedef logic signed [spd_pkg::COORD_W-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic dropped;
		logic last;
	} sorted_point_t;

	// clock, reset and block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic set_end = 1'b0;
	logic sorted_ready = 1'b0;
	coord_t point_x = '0;
	coord_t point_y = '0;
	coord_t target_x = '0;
	coord_t target_y = '0;

	logic point_ready;
	logic sorted_valid;
	coord_t sorted_x;
	coord_t sorted_y;
	logic dropped;
	logic final_result;

	// idling controls, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct = 0;

	// run statistics
	int mismatches = 0;
	int n_points = 0;
	int n_sets = 0;
	int n_results = 0;
	int n_overflow_sets = 0;

	// predictor state: the set being collected, kept in sorted order
	coord_t set_x [CAPACITY];
	coord_t set_y [CAPACITY];
	logic [spd_pkg::KEY_W-1:0] set_key [CAPACITY];
	int set_fill = 0;
	coord_t aim_x = '0;
	coord_t aim_y = '0;
	logic set_overflow = 1'b0;
	sorted_point_t expected_order [$];

	sort_points_by_distance #(
		.MAX_POINTS(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point_x(point_x),
		.point_y(point_y),
		.target_x(target_x),
		.target_y(target_y),
		.set_end(set_end),
		.sorted_valid(sorted_valid),
		.sorted_ready(sorted_ready),
		.sorted_x(sorted_x),
		.sorted_y(sorted_y),
		.dropped(dropped),
		.final_result(final_result)
	);

	always #HALF_PERIOD clk = ~clk;

	// squared distance, exact in KEY_W bits
	function automatic logic [spd_pkg::KEY_W-1:0] squared_distance(coord_t px, coord_t py,
			coord_t tx, coord_t ty);
		logic signed [spd_pkg::DIFF_W-1:0] dx;
		logic signed [spd_pkg::DIFF_W-1:0] dy;
		logic [spd_pkg::DIFF_W-1:0] mag_x;
		logic [spd_pkg::DIFF_W-1:0] mag_y;
		logic [spd_pkg::KEY_W-1:0] ax;
		logic [spd_pkg::KEY_W-1:0] ay;
		dx = {px[spd_pkg::COORD_W-1], px} - {tx[spd_pkg::COORD_W-1], tx};
		dy = {py[spd_pkg::COORD_W-1], py} - {ty[spd_pkg::COORD_W-1], ty};
		mag_x = dx[spd_pkg::DIFF_W-1] ? -dx : dx;
		mag_y = dy[spd_pkg::DIFF_W-1] ? -dy : dy;
		ax = spd_pkg::KEY_W'(mag_x);
		ay = spd_pkg::KEY_W'(mag_y);
		return ax * ax + ay * ay;
	endfunction

	// take one accepted point request into the predicted set
	task automatic record_point(coord_t px, coord_t py, coord_t tx, coord_t ty, logic last);
		logic [spd_pkg::KEY_W-1:0] k;
		int pos;
		sorted_point_t sp;
		if (set_fill == 0) begin
			aim_x = tx;
			aim_y = ty;
		end
		if (set_fill < CAPACITY) begin
			// stable insertion: only strictly larger keys move up
			k = squared_distance(px, py, aim_x, aim_y);
			pos = set_fill;
			while (pos > 0 && set_key[pos-1] > k) begin
				set_key[pos] = set_key[pos-1];
				set_x[pos] = set_x[pos-1];
				set_y[pos] = set_y[pos-1];
				pos--;
			end
			set_key[pos] = k;
			set_x[pos] = px;
			set_y[pos] = py;
			set_fill++;
		end else begin
			set_overflow = 1'b1;
		end
		n_points++;
		if (last) begin
			for (int i = 0; i < set_fill; i++) begin
				sp.x = set_x[i];
				sp.y = set_y[i];
				sp.dropped = set_overflow;
				sp.last = (i == set_fill - 1);
				expected_order.push_back(sp);
			end
			n_sets++;
			if (set_overflow)
				n_overflow_sets++;
			set_fill = 0;
			set_overflow = 1'b0;
		end
	endtask

	// send one point request, with random idle cycles ahead of it
	task automatic send_point(coord_t px, coord_t py, coord_t tx, coord_t ty, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		target_x <= tx;
		target_y <= ty;
		set_end <= last;
		@(posedge clk);
		while (!point_ready)
			@(posedge clk);
		record_point(px, py, tx, ty, last);
	endtask

	// hold off the sender until every predicted result has come out
	task automatic wait_results_drained();
		point_valid <= 1'b0;
		while (expected_order.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// result checker and random receiver stall
	always @(posedge clk) begin : check_results
		sorted_point_t head;
		if (arst_n && sorted_valid && sorted_ready) begin
			n_results++;
			if (expected_order.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result x=%0d y=%0d dropped=%b final=%b",
						$realtime, sorted_x, sorted_y, dropped, final_result);
			end else begin
				head = expected_order.pop_front();
				if (sorted_x !== head.x || sorted_y !== head.y ||
						dropped !== head.dropped || final_result !== head.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: mismatch exp x=%0d y=%0d dropped=%b final=%b,",
							" got x=%0d y=%0d dropped=%b final=%b"},
							$realtime, head.x, head.y, head.dropped, head.last,
							sorted_x, sorted_y, dropped, final_result);
				end
			end
		end
		sorted_ready <= ($urandom_range(99) >= stall_pct);
	end

	// corners of the coordinate range, both ways round
	task automatic test_extremes();
		send_point(32767, 32767, -32768, -32768, 1'b0);
		send_point(-32768, 32767, 0, 0, 1'b0);
		send_point(32767, -32768, 0, 0, 1'b0);
		send_point(-32768, -32768, 0, 0, 1'b1);
		send_point(-32768, -32768, 32767, 32767, 1'b0);
		send_point(0, 0, 0, 0, 1'b0);
		send_point(-1, 32767, 0, 0, 1'b1);
	endtask

	// equal distances must leave in arrival order
	task automatic test_equal_distances();
		send_point(16, 0, 0, 0, 1'b0);
		send_point(0, 16, 0, 0, 1'b0);
		send_point(-16, 0, 0, 0, 1'b0);
		send_point(0, 0, 0, 0, 1'b0);
		send_point(0, -16, 0, 0, 1'b0);
		send_point(16, 0, 0, 0, 1'b1);
	endtask

	// a set of one point
	task automatic test_single_point();
		send_point(-1234, 567, 89, -10, 1'b1);
	endtask

	// target fields on later points of a set are ignored
	task automatic test_target_sampling();
		send_point(100, 100, 100, 100, 1'b0);
		send_point(-200, 300, -200, 300, 1'b0);
		send_point(50, 60, 50, 60, 1'b0);
		send_point(400, -400, 400, -400, 1'b1);
	endtask

	// a full set, then a set past capacity ending on a dropped point
	task automatic test_capacity();
		for (int i = 0; i < CAPACITY; i++)
			send_point(coord_t'(i * 37 - 500), coord_t'(300 - i * 11), 20, -20,
				i == CAPACITY - 1);
		for (int i = 0; i < CAPACITY + 2; i++)
			send_point(coord_t'(700 - i * 53), coord_t'((i % 5) * 16), -50, 50,
				i == CAPACITY + 1);
	endtask

	// random coordinate: full range, a small grid that makes ties, or range corners
	function automatic coord_t rand_coord(int mode);
		int v;
		case (mode)
			0: begin
				v = $urandom_range(16'hFFFF);
				return coord_t'(v);
			end
			1: begin
				v = $urandom_range(6);
				return coord_t'((v - 3) * 16);
			end
			default: begin
				v = $urandom_range(3);
				case (v)
					0: return coord_t'(-32768);
					1: return coord_t'(32767);
					2: return coord_t'(-1);
					default: return coord_t'(0);
				endcase
			end
		endcase
	endfunction

	// random sets, mostly small, a few near or past capacity
	task automatic test_random_sets(int send_pct, int recv_pct, int item_goal);
		int sent;
		int size;
		int mode;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		sent = 0;
		while (sent < item_goal) begin
			size = ($urandom_range(99) < 8) ? $urandom_range(CAPACITY + 4, CAPACITY - 2)
				: $urandom_range(8, 1);
			mode = $urandom_range(2);
			for (int i = 0; i < size; i++)
				send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(0), i == size - 1);
			sent += size;
		end
		wait_results_drained();
	endtask

	// test sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_equal_distances();
		test_single_point();
		test_target_sampling();
		test_capacity();
		wait_results_drained();
		test_random_sets(0, 0, 22);
		test_random_sets(68, 0, 22);
		test_random_sets(0, 68, 22);
		test_random_sets(10, 10, 22);
		$display("Sent %0d points in %0d sets (%0d past capacity), checked %0d results",
			n_points, n_sets, n_overflow_sets, n_results);
		$display("Idling covered: none, sender 68%%, receiver 68%%, both 10%%");
		if (mismatches == 0 && expected_order.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// run time limit
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule

// File: sort_points_by_distance.f
sv/spd_pkg.sv
sv/spd_front.sv
sv/spd_queue.sv
sv/spd_back.sv
sv/sort_points_by_distance.sv
sv/spd_checker.sv
test/tb_sort_points_by_distance.sv
